[sv/a2b_pkg.sv]
// Shared types and constants for the length-prefixed to start-code converter.
package a2b_pkg;

  // Fixed widths of the item fields
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 32;
  localparam int unsigned RoleW   = 2;
  localparam int unsigned KindW   = 2;

  // Default for the parsed part of buffer_length
  localparam int unsigned BufferLengthBitsDefault = 32;

  // Unit length header size in bytes
  localparam int unsigned HdrBytes = 4;

  // NAL unit type field and the parameter set types
  localparam logic [ByteW-1:0] NalTypeMask = 8'h1F;
  localparam logic [ByteW-1:0] NalTypeSps  = 8'd7;
  localparam logic [ByteW-1:0] NalTypePps  = 8'd8;

  // Byte role codes
  localparam logic [RoleW-1:0] RoleRemainder = 2'd0;
  localparam logic [RoleW-1:0] RoleStartCode = 2'd1;
  localparam logic [RoleW-1:0] RolePayload   = 2'd2;

  // Unit kind codes
  localparam logic [KindW-1:0] KindOther = 2'd0;
  localparam logic [KindW-1:0] KindSps   = 2'd1;
  localparam logic [KindW-1:0] KindPps   = 2'd2;

  // Start code bytes: 00 00 00 01
  localparam logic [ByteW-1:0] ScZero = 8'h00;
  localparam logic [ByteW-1:0] ScOne  = 8'h01;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_FIRST   = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_REST    = 4'b1000
  } phase_e;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [RoleW-1:0] byte_role;
    logic [KindW-1:0] unit_kind;
    logic             unit_first;
    logic             unit_last;
    logic             buffer_last;
  } out_item_t;

  // Map the first payload byte to a unit kind
  function automatic logic [KindW-1:0] kind_of(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] t;
    t = b & NalTypeMask;
    if (t == NalTypeSps) begin
      return KindSps;
    end else if (t == NalTypePps) begin
      return KindPps;
    end
    return KindOther;
  endfunction

endpackage

[sv/a2b_in_if.sv]
// Input channel: one byte of a length-prefixed buffer per transaction.
interface a2b_in_if;
  logic                        valid;
  logic                        ready;
  logic [a2b_pkg::ByteW-1:0]   data_byte;
  logic                        buffer_start;
  logic [a2b_pkg::LenW-1:0]    buffer_length;

  modport source (output valid, output data_byte, output buffer_start,
                  output buffer_length, input ready);
  modport sink   (input valid, input data_byte, input buffer_start,
                  input buffer_length, output ready);
endinterface

[sv/a2b_out_if.sv]
// Output channel: one converted byte with its tags per transaction.
interface a2b_out_if;
  logic                        valid;
  logic                        ready;
  logic [a2b_pkg::ByteW-1:0]   out_byte;
  logic [a2b_pkg::RoleW-1:0]   byte_role;
  logic [a2b_pkg::KindW-1:0]   unit_kind;
  logic                        unit_first;
  logic                        unit_last;
  logic                        buffer_last;

  modport source (output valid, output out_byte, output byte_role, output unit_kind,
                  output unit_first, output unit_last, output buffer_last, input ready);
  modport sink   (input valid, input out_byte, input byte_role, input unit_kind,
                  input unit_first, input unit_last, input buffer_last, output ready);
endinterface

[sv/avcc_to_annexb_converter.sv]
// Top level: converts length-prefixed H.264 bytes to start-code framing.
// Each result is captured in the output register when its input transaction is accepted.
// Throughput: one byte per cycle while the output accepts; the parse state updates in the accepting cycle.
// The output register frees in the same cycle it is taken, so input stalls only on out stall.
// Reset: asynchronous, clears parse state to header phase with no active buffer.
module avcc_to_annexb_converter #(
  parameter int unsigned BUFFER_LENGTH_BITS = a2b_pkg::BufferLengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  a2b_in_if.sink      in_i,
  a2b_out_if.source   out_o
);

  localparam int unsigned BlW = BUFFER_LENGTH_BITS;

  // Parse state
  a2b_pkg::phase_e           phase_q, phase_d;
  logic [1:0]                hdr_idx_q, hdr_idx_d;
  logic [a2b_pkg::LenW-1:0]  len_acc_q, len_acc_d;
  logic [BlW-1:0]            payload_left_q, payload_left_d;
  logic [BlW-1:0]            buffer_left_q, buffer_left_d;
  logic [a2b_pkg::KindW-1:0] kind_q, kind_d;

  // Output register
  logic                      out_valid_q;
  a2b_pkg::out_item_t        out_item_q, out_item_d;

  logic                      in_fire;
  logic                      out_fire;

  // Working copies after a buffer start is applied
  a2b_pkg::phase_e           ph_s;
  logic [1:0]                idx_s;
  logic [a2b_pkg::LenW-1:0]  acc_s;
  logic [BlW-1:0]            pl_s;
  logic [BlW-1:0]            bl_s;
  logic [a2b_pkg::KindW-1:0] kind_s;
  logic [BlW-1:0]            rem;
  logic [a2b_pkg::LenW-1:0]  acc_new;

  assign out_fire = out_valid_q & out_o.ready;
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign in_fire  = in_i.valid & in_i.ready;

  // Compute the next parse state and the result for the offered byte
  always_comb begin
    if (in_i.buffer_start) begin
      ph_s   = a2b_pkg::PH_HEADER;
      idx_s  = 2'd0;
      acc_s  = '0;
      pl_s   = '0;
      bl_s   = in_i.buffer_length[BlW-1:0];
      kind_s = a2b_pkg::KindOther;
    end else begin
      ph_s   = phase_q;
      idx_s  = hdr_idx_q;
      acc_s  = len_acc_q;
      pl_s   = payload_left_q;
      bl_s   = buffer_left_q;
      kind_s = kind_q;
    end

    rem     = bl_s - BlW'(1);
    acc_new = {acc_s[a2b_pkg::LenW-a2b_pkg::ByteW-1:0], in_i.data_byte};

    phase_d        = ph_s;
    hdr_idx_d      = idx_s;
    len_acc_d      = acc_s;
    payload_left_d = pl_s;
    buffer_left_d  = bl_s;
    kind_d         = kind_s;

    out_item_d             = '0;
    out_item_d.out_byte    = in_i.data_byte;
    out_item_d.byte_role   = a2b_pkg::RoleRemainder;
    out_item_d.unit_kind   = a2b_pkg::KindOther;

    if (bl_s != '0) begin
      out_item_d.buffer_last = (bl_s == BlW'(1));
      // Drop to pass-through when a header cannot fit
      if (ph_s == a2b_pkg::PH_HEADER && idx_s == 2'd0 && bl_s < BlW'(a2b_pkg::HdrBytes)) begin
        phase_d = a2b_pkg::PH_REST;
      end

      case (phase_d)
        a2b_pkg::PH_HEADER: begin
          out_item_d.byte_role = a2b_pkg::RoleStartCode;
          out_item_d.out_byte  = (idx_s == 2'd3) ? a2b_pkg::ScOne : a2b_pkg::ScZero;
          if (idx_s == 2'd3) begin
            hdr_idx_d = 2'd0;
            len_acc_d = '0;
            if (acc_new == '0) begin
              phase_d = a2b_pkg::PH_HEADER;
            end else if (a2b_pkg::LenW'(rem) < acc_new) begin
              phase_d = a2b_pkg::PH_REST;
            end else begin
              payload_left_d = acc_new[BlW-1:0];
              phase_d        = a2b_pkg::PH_FIRST;
            end
          end else begin
            hdr_idx_d = idx_s + 2'd1;
            len_acc_d = acc_new;
          end
        end
        a2b_pkg::PH_FIRST, a2b_pkg::PH_PAYLOAD: begin
          out_item_d.byte_role = a2b_pkg::RolePayload;
          if (phase_d == a2b_pkg::PH_FIRST) begin
            kind_d                = a2b_pkg::kind_of(in_i.data_byte);
            out_item_d.unit_first = 1'b1;
          end
          out_item_d.unit_kind = kind_d;
          if (pl_s <= BlW'(1)) begin
            out_item_d.unit_last = 1'b1;
            payload_left_d       = '0;
            phase_d              = a2b_pkg::PH_HEADER;
            hdr_idx_d            = 2'd0;
          end else begin
            payload_left_d = pl_s - BlW'(1);
            phase_d        = a2b_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          out_item_d.byte_role = a2b_pkg::RoleRemainder;
        end
      endcase
      buffer_left_d = rem;
    end
  end

  // Advance parse state on each input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= a2b_pkg::PH_HEADER;
      hdr_idx_q      <= 2'd0;
      len_acc_q      <= '0;
      payload_left_q <= '0;
      buffer_left_q  <= '0;
      kind_q         <= a2b_pkg::KindOther;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      hdr_idx_q      <= hdr_idx_d;
      len_acc_q      <= len_acc_d;
      payload_left_q <= payload_left_d;
      buffer_left_q  <= buffer_left_d;
      kind_q         <= kind_d;
    end
  end

  // Hold the result until the output transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_item_q.out_byte;
  assign out_o.byte_role   = out_item_q.byte_role;
  assign out_o.unit_kind   = out_item_q.unit_kind;
  assign out_o.unit_first  = out_item_q.unit_first;
  assign out_o.unit_last   = out_item_q.unit_last;
  assign out_o.buffer_last = out_item_q.buffer_last;

  // A unit awaiting its first payload byte always has a nonzero length
  a_first_has_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == a2b_pkg::PH_FIRST) |-> (payload_left_q != '0))
    else $error("first payload phase with zero unit length");

  // A header in progress always has bytes left in the buffer
  a_hdr_in_buffer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_idx_q != 2'd0) |-> (phase_q == a2b_pkg::PH_HEADER && buffer_left_q != '0))
    else $error("header index set outside an active header");

  // Each byte inside an active buffer consumes exactly one count
  a_count_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_i.buffer_start && buffer_left_q != '0)
      |=> (buffer_left_q == $past(buffer_left_q) - BlW'(1)))
    else $error("buffer byte count did not step down by one");

  // A first-byte tag is set only on a payload result
  a_first_tag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_item_d.unit_first) |-> (out_item_d.byte_role == a2b_pkg::RolePayload))
    else $error("first-byte tag on a non-payload byte");

endmodule

[bench/a2b_checker.sv]
// Converter checker: tracks the byte stream, predicts each output byte and compares it.
`timescale 1ns / 100ps

module a2b_checker
  import a2b_pkg::*;
#(
  parameter int unsigned BUFFER_LENGTH_BITS = BufferLengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  a2b_in_if           in_i,
  a2b_out_if          out_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned      MaxReports = 10;
  localparam logic [LenW-1:0]  LenMask    = {LenW{1'b1}} >> (LenW - BUFFER_LENGTH_BITS);

  // Parse state of the predictor
  phase_e           ph;
  logic [1:0]       hdr_idx;
  logic [LenW-1:0]  len_acc;
  logic [LenW-1:0]  pay_left;
  logic [LenW-1:0]  buf_left;
  logic [KindW-1:0] cur_kind;

  out_item_t   expected_bytes[$];
  int unsigned errs;

  function automatic string fmt_item(input out_item_t it);
    return $sformatf("byte %02h role %0d kind %0d first %0b last %0b buffer_last %0b",
                     it.out_byte, it.byte_role, it.unit_kind, it.unit_first,
                     it.unit_last, it.buffer_last);
  endfunction

  // Advance the parse by one input byte and queue the converted byte it yields
  task automatic convert_byte(input logic [ByteW-1:0] b, input logic st,
                              input logic [LenW-1:0] len);
    out_item_t   e;
    logic [LenW-1:0] rem;
    e             = '0;
    e.out_byte    = b;
    e.byte_role   = RoleRemainder;
    e.unit_kind   = KindOther;
    // A buffer start drops whatever parse was in progress
    if (st) begin
      buf_left = len & LenMask;
      ph       = PH_HEADER;
      hdr_idx  = '0;
      len_acc  = '0;
      pay_left = '0;
      cur_kind = KindOther;
    end
    if (buf_left != '0) begin
      e.buffer_last = (buf_left == 1);
      // Too few bytes left for a length header: pass the tail through
      if (ph == PH_HEADER && hdr_idx == '0 && buf_left < HdrBytes) ph = PH_REST;
      rem = buf_left - 1;
      case (ph)
        PH_HEADER: begin
          e.byte_role = RoleStartCode;
          e.out_byte  = (hdr_idx == 2'(HdrBytes - 1)) ? ScOne : ScZero;
          len_acc     = {len_acc[LenW-ByteW-1:0], b};
          if (hdr_idx == 2'(HdrBytes - 1)) begin
            hdr_idx = '0;
            if (len_acc == '0) begin
              ph = PH_HEADER;
            end else if (rem < len_acc) begin
              ph = PH_REST;
            end else begin
              pay_left = len_acc;
              ph       = PH_FIRST;
            end
            len_acc = '0;
          end else begin
            hdr_idx = hdr_idx + 1'b1;
          end
        end
        PH_FIRST, PH_PAYLOAD: begin
          e.byte_role = RolePayload;
          if (ph == PH_FIRST) begin
            if ((b & NalTypeMask) == NalTypeSps) begin
              cur_kind = KindSps;
            end else if ((b & NalTypeMask) == NalTypePps) begin
              cur_kind = KindPps;
            end else begin
              cur_kind = KindOther;
            end
            e.unit_first = 1'b1;
          end
          e.unit_kind = cur_kind;
          if (pay_left <= 1) begin
            e.unit_last = 1'b1;
            pay_left    = '0;
            ph          = PH_HEADER;
            hdr_idx     = '0;
          end else begin
            pay_left = pay_left - 1;
            ph       = PH_PAYLOAD;
          end
        end
        default: begin
        end
      endcase
      buf_left = rem;
    end
    expected_bytes = {expected_bytes, e};
  endtask

  // Compare each output transaction, then predict from each input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      ph       = PH_HEADER;
      hdr_idx  = '0;
      len_acc  = '0;
      pay_left = '0;
      buf_left = '0;
      cur_kind = KindOther;
      errs     = 0;
      expected_bytes.delete();
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.out_byte    = out_i.out_byte;
        got.byte_role   = out_i.byte_role;
        got.unit_kind   = out_i.unit_kind;
        got.unit_first  = out_i.unit_first;
        got.unit_last   = out_i.unit_last;
        got.buffer_last = out_i.buffer_last;
        if (expected_bytes.size() == 0) begin
          errs++;
          if (errs <= MaxReports) begin
            $display("%0t: output with nothing expected: %s", $realtime, fmt_item(got));
          end
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte || got.byte_role !== want.byte_role ||
              got.unit_kind !== want.unit_kind || got.unit_first !== want.unit_first ||
              got.unit_last !== want.unit_last || got.buffer_last !== want.buffer_last) begin
            errs++;
            if (errs <= MaxReports) begin
              $display("%0t: mismatch, expected %s", $realtime, fmt_item(want));
              $display("%0t:           actual   %s", $realtime, fmt_item(got));
            end
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        convert_byte(in_i.data_byte, in_i.buffer_start, in_i.buffer_length);
      end
      mismatch_cnt_o <= errs;
      pending_o      <= expected_bytes.size();
    end
  end

endmodule

[bench/tb_top.sv]
// Converter testbench top: clock, reset, byte stimulus, output pacing and verdict.
`timescale 1ns / 100ps

module tb_top;
  import a2b_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned RandItems   = 850;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned HoldAfter   = 200;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        calm;
  int unsigned sent;
  int unsigned rx_cnt   = 0;
  int unsigned idle_cnt = 0;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  // Bytes of the buffer being assembled
  logic [ByteW-1:0] buf_q[$];

  a2b_in_if  in_ch ();
  a2b_out_if out_ch ();

  avcc_to_annexb_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  a2b_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_ch),
    .out_i          (out_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte and hold it until the converter takes it
  task automatic send_byte(input logic [ByteW-1:0] b, input logic st,
                           input logic [LenW-1:0] len);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : gap_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.buffer_start  <= st;
    in_ch.buffer_length <= len;
    calm                <= (sent % 300) >= 250;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  // Send the first count bytes of the assembled buffer, announcing declared as its size
  task automatic send_buf(input logic [LenW-1:0] declared, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_byte(buf_q[i], i == 0, (i == 0) ? declared : LenW'($urandom()));
    end
    buf_q.delete();
  endtask

  // Append a length header and body bytes; the first body byte leans toward parameter sets
  task automatic add_unit(input logic [LenW-1:0] ulen, input int unsigned body);
    int unsigned pick;
    for (int k = HdrBytes - 1; k >= 0; k--) begin
      buf_q = {buf_q, ulen[ByteW*k +: ByteW]};
    end
    for (int unsigned j = 0; j < body; j++) begin
      pick = $urandom_range(0, 3);
      if (j == 0 && pick == 0) begin
        buf_q = {buf_q, {3'($urandom()), NalTypeSps[4:0]}};
      end else if (j == 0 && pick == 1) begin
        buf_q = {buf_q, {3'($urandom()), NalTypePps[4:0]}};
      end else begin
        buf_q = {buf_q, ByteW'($urandom())};
      end
    end
  endtask

  // Count accepted output transactions
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) rx_cnt <= rx_cnt + 1;
  end

  // Watchdog: end the run after a long stretch with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Output pacing: random stalls, one long hold-off so the input backs up
  initial begin : out_pacing
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && rx_cnt >= HoldAfter) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (gap_len()) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned     mode;
    int unsigned     nunits;
    int unsigned     full;
    int unsigned     body;
    int unsigned     target;
    logic [LenW-1:0] ulen;
    logic [LenW-1:0] declared;

    sent                 = 0;
    rst_ni               = 1'b0;
    calm                <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.buffer_start  <= 1'b0;
    in_ch.buffer_length <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bytes outside any buffer: right after reset, then a zero-length buffer
    send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1, 32'h0000_0000);
    // Sequence parameter set that ends exactly with the buffer
    buf_q = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h67, 8'h42, 8'hFF};
    send_buf(7, 7);
    // Picture parameter set
    buf_q = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h68, 8'hCE};
    send_buf(6, 6);
    // Zero unit length, then a tail too short for a header
    buf_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hA5};
    send_buf(5, 5);
    // Largest unit length, far longer than the buffer
    buf_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_buf(4, 4);
    // Single-byte buffer
    buf_q = '{8'h7F};
    send_buf(1, 1);

    // Random buffers, mostly well formed
    target = sent + RandItems;
    while (sent < target) begin
      mode   = $urandom_range(0, 99);
      nunits = $urandom_range(1, 4);
      for (int unsigned u = 0; u < nunits; u++) begin
        ulen = ($urandom_range(0, 9) == 0) ? '0 : LenW'($urandom_range(1, 12));
        if ($urandom_range(0, 19) == 0) ulen = LenW'($urandom_range(13, 60));
        add_unit(ulen, ulen);
      end
      full = buf_q.size();
      if (mode < 60) begin
        send_buf(full, full);
      end else if (mode < 70) begin
        // Short header tail
        repeat ($urandom_range(1, 3)) buf_q = {buf_q, ByteW'($urandom())};
        send_buf(buf_q.size(), buf_q.size());
      end else if (mode < 78) begin
        // Last unit claims more than is left
        body = $urandom_range(0, 5);
        ulen = $urandom_range(0, 1) ? LenW'(body + $urandom_range(1, 3)) : LenW'($urandom());
        if (ulen <= body) ulen = body + 1;
        add_unit(ulen, body);
        send_buf(buf_q.size(), buf_q.size());
      end else if (mode < 84) begin
        // Noise
        buf_q.delete();
        repeat ($urandom_range(1, 20)) buf_q = {buf_q, ByteW'($urandom())};
        send_buf(buf_q.size(), buf_q.size());
      end else if (mode < 92) begin
        // Cut short by the next buffer start
        declared = $urandom_range(0, 1) ? LenW'(full + $urandom_range(0, 5))
                                        : LenW'(32'hFFFF_FFFF - $urandom_range(0, 255));
        send_buf(declared, $urandom_range(1, full));
      end else if (mode < 96) begin
        // Declared too short: the extra bytes fall outside the buffer
        send_buf($urandom_range(1, full), full);
      end else begin
        send_buf('0, $urandom_range(1, 4));
      end
    end
    in_ch.valid <= 1'b0;

    // Drain the outstanding results
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
